/* sv/ipr_pkg.sv */
// Shared types, constants and register codes for the isolated pixel removal block.
package ipr_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_RING_AW    = $clog2(DEF_MAX_WIDTH + 3);
  localparam int CFG_W          = 11;
  localparam int PIX_W          = 8;
  localparam int OQ_DEPTH       = 4;

  localparam logic [CFG_W-1:0] RESET_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 11'd480;

  typedef logic [PIX_W-1:0] pixel_t;

  localparam pixel_t PIX_WHITE = 8'd255;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_FLUSH = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t  kind;
    pixel_t pixel_in;
  } in_beat_t;

  typedef struct packed {
    pixel_t pixel_out;
    logic   frame_end;
  } out_beat_t;

  // Per-release control handed from the address stage to the judge stage.
  typedef struct packed {
    logic   interior;
    logic   frame_end;
    logic   right_ok;
    pixel_t bot_l;
    pixel_t bot_c;
    pixel_t bot_r;
  } judge_ctl_t;

endpackage

/* sv/ipr_ring.sv */
// Ring buffer of received pixels: one write port, two registered read ports.
module ipr_ring #(
  parameter int AW = ipr_pkg::DEF_RING_AW
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  ipr_pkg::pixel_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr_a,
  input  logic [AW-1:0]   raddr_b,
  output ipr_pkg::pixel_t rdata_a,
  output ipr_pkg::pixel_t rdata_b
);
  import ipr_pkg::*;

  localparam int DEPTH = 1 << AW;

  pixel_t store [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= store[raddr_a];
      rdata_b <= store[raddr_b];
    end
  end

endmodule

/* sv/ipr_line.sv */
// Line buffer of cleaned pixels, indexed by column.
module ipr_line #(
  parameter int DEPTH = ipr_pkg::DEF_MAX_WIDTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  ipr_pkg::pixel_t          wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output ipr_pkg::pixel_t          rdata
);
  import ipr_pkg::*;

  pixel_t store [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= store[raddr];
    end
  end

endmodule

/* sv/ipr_judge.sv */
// Neighborhood test for the released pixel; keeps the upper-row and left taps.
module ipr_judge (
  input  logic                clk,
  input  logic                s1_valid,
  input  ipr_pkg::judge_ctl_t ctl,
  input  ipr_pkg::pixel_t     center,
  input  ipr_pkg::pixel_t     right,
  input  ipr_pkg::pixel_t     top_r,
  output ipr_pkg::pixel_t     result
);
  import ipr_pkg::*;

  pixel_t     top_c;
  pixel_t     top_l;
  pixel_t     left;
  logic [7:0] nz;
  logic       lone;

  always_comb begin
    nz   = {top_l != '0, top_c != '0, top_r != '0, left != '0,
            ctl.right_ok && (right != '0),
            ctl.bot_l != '0, ctl.bot_c != '0, ctl.bot_r != '0};
    // at most one bit set
    lone = (nz & (nz - 8'd1)) == 8'd0;
    if (ctl.interior && (center == PIX_WHITE) && lone) begin
      result = '0;
    end else begin
      result = center;
    end
  end

  // releases are consecutive in raster order, so the taps simply shift
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      top_l <= top_c;
      top_c <= top_r;
      left  <= result;
    end
  end

endmodule

/* sv/ipr_oq.sv */
// Small result queue with a look-ahead full flag for the input side.
module ipr_oq #(
  parameter int DEPTH = ipr_pkg::OQ_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ipr_pkg::out_beat_t push_beat,
  input  logic               in_flight,
  output logic               full_soon,
  output logic               res_valid,
  input  logic               res_stall,
  output ipr_pkg::out_beat_t res_beat
);
  import ipr_pkg::*;

  localparam int PTRW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  out_beat_t       slots [DEPTH];
  logic [PTRW-1:0] rd_idx;
  logic [PTRW-1:0] wr_idx;
  logic [CNTW-1:0] level;
  logic            pop;

  assign pop       = res_valid && !res_stall;
  assign res_valid = level != '0;
  assign res_beat  = slots[rd_idx];
  // room for the beat in the judge stage and one more entering now
  assign full_soon = ((CNTW+1)'(level) + (CNTW+1)'(in_flight)) >= (CNTW+1)'(DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_idx] <= push_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
      wr_idx <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_idx <= (wr_idx == PTRW'(DEPTH - 1)) ? '0 : wr_idx + PTRW'(1);
      end
      if (pop) begin
        rd_idx <= (rd_idx == PTRW'(DEPTH - 1)) ? '0 : rd_idx + PTRW'(1);
      end
      case ({push, pop})
        2'b10:   level <= level + CNTW'(1);
        2'b01:   level <= level - CNTW'(1);
        default: level <= level;
      endcase
    end
  end

endmodule

/* sv/isolated_pixel_removal.sv */
// Top level of the isolated white pixel remover (3x3, raster order, in place).
// Takes one beat per cycle, pixel or flush, and sustains that rate as long as
// results are taken; the input stalls whenever the four-entry result queue and
// the judge stage together hold four results. A pixel beat at raster position p
// releases the final value of position p-(width+1). The synchronous memory reads
// register that pixel and its taps, the neighbor test on them is combinational,
// and the result queue registers the outcome before it shows on res_valid. Flush
// beats release one pending pixel each while any are pending, with neighbors not
// yet received taken as zero. Received pixels live in a ring memory (one write,
// two reads), cleaned pixels of the row above in a column-indexed line memory;
// the lower row comes from the last received beats. No clearing pass is needed
// after reset. Writing image_width or image_height restarts the stream and drops
// pending pixels; write them only while the block is idle.
module isolated_pixel_removal #(
  parameter int MAX_WIDTH  = ipr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ipr_pkg::DEF_MAX_HEIGHT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  ipr_pkg::cfg_reg_t         cfg_index,
  input  logic [ipr_pkg::CFG_W-1:0] cfg_data,
  input  logic                      px_valid,
  output logic                      px_stall,
  input  ipr_pkg::in_beat_t         px_beat,
  output logic                      res_valid,
  input  logic                      res_stall,
  output ipr_pkg::out_beat_t        res_beat
);
  import ipr_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);   // effective width value
  localparam int HW = $clog2(MAX_HEIGHT + 1);  // effective height value
  localparam int CW = $clog2(MAX_WIDTH);       // column index
  localparam int RW = $clog2(MAX_HEIGHT);      // row index
  localparam int PW = $clog2(MAX_WIDTH + 3);   // ring address and pending count

  // configuration
  logic [CFG_W-1:0] cfg_width;
  logic [CFG_W-1:0] cfg_height;
  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;

  // stream state
  logic [PW-1:0] pending;
  logic [PW-1:0] pending_next;
  logic [PW-1:0] wr_ptr;
  logic [CW-1:0] out_col;
  logic [RW-1:0] out_row;
  pixel_t        in0;   // newest received pixel
  pixel_t        in1;   // the one before it

  // address stage
  logic          accept;
  logic          is_flush;
  logic          rel;
  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] avail;
  logic [PW-1:0] deficit;
  logic          last_col;
  logic          last_row;
  logic [CW-1:0] top_addr;
  judge_ctl_t    s0_ctl;

  // judge stage
  logic          s1_valid;
  judge_ctl_t    s1_ctl;
  logic [CW-1:0] s1_col;
  pixel_t        center;
  pixel_t        right;
  pixel_t        top_r;
  pixel_t        result;
  out_beat_t     s1_beat;
  logic          full_soon;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= RESET_WIDTH;
      cfg_height <= RESET_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  cfg_width  <= cfg_data;
        REG_IMAGE_HEIGHT: cfg_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero reads as one, oversize values clamp to MAX_WIDTH and MAX_HEIGHT
  always_comb begin
    if (cfg_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg_width) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_width);
    end
    if (cfg_height == '0) begin
      h_eff = HW'(1);
    end else if (32'(cfg_height) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(cfg_height);
    end
  end

  assign px_stall = full_soon;
  assign accept   = px_valid && !px_stall;
  assign is_flush = px_beat.kind == KIND_FLUSH;

  // pixel beat releases once width+1 pixels are pending; flush whenever any are
  assign rel = accept && (is_flush ? (pending != '0) : (pending > PW'(w_eff)));

  assign rd_ptr   = wr_ptr - pending;
  assign last_col = out_col == CW'(w_eff - WW'(1));
  assign last_row = out_row == RW'(h_eff - HW'(1));
  // cleaned pixel one row up, one column right; wraps to column 0 at row end
  assign top_addr = last_col ? '0 : out_col + CW'(1);

  // pixels received counting this beat; lower-row taps slide by the shortfall
  assign avail   = is_flush ? pending : pending + PW'(1);
  assign deficit = PW'(w_eff) + PW'(2) - avail;

  always_comb begin
    s0_ctl.interior  = (out_row != '0) &&
                       ((HW+1)'(out_row) + (HW+1)'(2) <= (HW+1)'(h_eff)) &&
                       (out_col != '0) &&
                       ((WW+1)'(out_col) + (WW+1)'(2) <= (WW+1)'(w_eff));
    s0_ctl.frame_end = last_row && last_col;
    s0_ctl.right_ok  = !is_flush || (pending > PW'(1));
    s0_ctl.bot_l     = '0;
    s0_ctl.bot_c     = '0;
    s0_ctl.bot_r     = '0;
    if (!is_flush) begin
      s0_ctl.bot_l = in1;
      s0_ctl.bot_c = in0;
      s0_ctl.bot_r = px_beat.pixel_in;
    end else if (deficit == PW'(1)) begin
      s0_ctl.bot_l = in1;
      s0_ctl.bot_c = in0;
    end else if (deficit == PW'(2)) begin
      s0_ctl.bot_l = in0;
    end
  end

  always_comb begin
    pending_next = pending;
    if (cfg_we) begin
      pending_next = '0;
    end else if (accept && !is_flush && !rel) begin
      pending_next = pending + PW'(1);
    end else if (accept && is_flush && rel) begin
      pending_next = pending - PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending  <= '0;
      wr_ptr   <= '0;
      out_col  <= '0;
      out_row  <= '0;
      s1_valid <= 1'b0;
    end else begin
      pending  <= pending_next;
      s1_valid <= rel;
      if (accept && !is_flush) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (cfg_we) begin
        out_col <= '0;
        out_row <= '0;
      end else if (rel) begin
        if (last_col) begin
          out_col <= '0;
          out_row <= last_row ? '0 : out_row + RW'(1);
        end else begin
          out_col <= out_col + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_flush) begin
      in1 <= in0;
      in0 <= px_beat.pixel_in;
    end
    if (rel) begin
      s1_ctl <= s0_ctl;
      s1_col <= out_col;
    end
  end

  ipr_ring #(
    .AW(PW)
  ) u_ring (
    .clk     (clk),
    .we      (accept && !is_flush),
    .waddr   (wr_ptr),
    .wdata   (px_beat.pixel_in),
    .re      (rel),
    .raddr_a (rd_ptr),
    .raddr_b (rd_ptr + PW'(1)),
    .rdata_a (center),
    .rdata_b (right)
  );

  // upper-row reads trail the matching write by width-1 releases, two or more when interior
  ipr_line #(
    .DEPTH(MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (result),
    .re    (rel),
    .raddr (top_addr),
    .rdata (top_r)
  );

  ipr_judge u_judge (
    .clk      (clk),
    .s1_valid (s1_valid),
    .ctl      (s1_ctl),
    .center   (center),
    .right    (right),
    .top_r    (top_r),
    .result   (result)
  );

  assign s1_beat.pixel_out = result;
  assign s1_beat.frame_end = s1_ctl.frame_end;

  ipr_oq #(
    .DEPTH(OQ_DEPTH)
  ) u_oq (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid),
    .push_beat (s1_beat),
    .in_flight (s1_valid),
    .full_soon (full_soon),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_beat  (res_beat)
  );

endmodule

/* sv/ipr_checker.sv */
// Port-level checks for the isolated pixel remover and their bind.
module ipr_port_checks (
  input logic               clk,
  input logic               rst,
  input logic               px_valid,
  input logic               px_stall,
  input logic               res_valid,
  input logic               res_stall,
  input ipr_pkg::out_beat_t res_beat
);
  import ipr_pkg::*;

  // with the result queue empty there is always room for a new beat
  a_no_stall_when_drained: assert property (
    @(posedge clk) disable iff (rst)
    !res_valid |-> !px_stall
  ) else $error("input stalled while no result is queued");

  // a rising res_valid must trace back to an accepted beat, registered through the judge stage and the result queue
  a_result_latency: assert property (
    @(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(px_valid && !px_stall, 2)
  ) else $error("result appeared without an accepted beat two cycles before");

  a_result_holds: assert property (
    @(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(res_beat))
  ) else $error("stalled result beat changed");

endmodule

bind isolated_pixel_removal ipr_port_checks u_ipr_checker (
  .clk       (clk),
  .rst       (rst),
  .px_valid  (px_valid),
  .px_stall  (px_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_beat  (res_beat)
);

/* verif/ipr_checker.sv */
// Checker for the isolated pixel remover: predicts the cleaned stream and compares results.
module ipr_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  ipr_pkg::cfg_reg_t         cfg_index,
  input  logic [ipr_pkg::CFG_W-1:0] cfg_data,
  input  logic                      px_valid,
  input  logic                      px_stall,
  input  ipr_pkg::in_beat_t         px_beat,
  input  logic                      res_valid,
  input  logic                      res_stall,
  input  ipr_pkg::out_beat_t        res_beat,
  output int                        due_count,
  output int                        fail_count,
  output int                        result_count
);
  import ipr_pkg::*;

  localparam int RING      = 2 * DEF_MAX_WIDTH + 3;
  localparam int PRINT_CAP = 200;

  // Received pixels, cleaned in place as they are released.
  pixel_t           ring_px [RING];
  int unsigned      wr_pos, held;
  int unsigned      in_row, in_col, out_row, out_col;
  logic [CFG_W-1:0] width_reg, height_reg;
  out_beat_t        cleaned_q [$];
  int               n_fail = 0;
  int               n_seen = 0;

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned lim);
    int unsigned d;
    d = v;
    if (d < 1) d = 1;
    if (d > lim) d = lim;
    return d;
  endfunction

  function automatic void next_pos(inout int unsigned r, inout int unsigned c,
                                   input int unsigned w, input int unsigned h);
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
  endfunction

  // Final value of the oldest pending pixel; neighbors not yet received count as zero.
  function automatic out_beat_t clean_oldest(input int unsigned w, input int unsigned h);
    int unsigned rp, idx, lit;
    int          d;
    pixel_t      v;
    logic        interior;
    out_beat_t   r;
    rp = (wr_pos + RING - held) % RING;
    v = ring_px[rp];
    interior = out_row >= 1 && out_row + 2 <= h && out_col >= 1 && out_col + 2 <= w;
    if (interior && v == PIX_WHITE) begin
      lit = 0;
      for (int k = 0; k < 9; k++) begin
        if (k != 4) begin
          d = (k / 3 - 1) * int'(w) + (k % 3 - 1);
          if (!(d > 0 && d >= int'(held))) begin
            idx = (int'(rp) + RING + d) % RING;
            if (ring_px[idx] != '0) lit++;
          end
        end
      end
      if (lit <= 1) begin
        v = '0;
        ring_px[rp] = '0;
      end
    end
    r.pixel_out = v;
    r.frame_end = (out_row == h - 1 && out_col == w - 1);
    held--;
    next_pos(out_row, out_col, w, h);
    return r;
  endfunction

  task automatic log_mismatch(input string msg);
    if (n_fail < PRINT_CAP) $display("mismatch: %s", msg);
    n_fail++;
  endtask

  always @(posedge clk) begin : watch
    int unsigned w, h;
    out_beat_t   want;
    if (rst) begin
      foreach (ring_px[i]) ring_px[i] = '0;
      wr_pos = 0;
      held = 0;
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      width_reg = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      cleaned_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_IMAGE_WIDTH) width_reg = cfg_data;
        else height_reg = cfg_data;
        // a write restarts the stream and drops pending pixels
        held = 0;
        in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      end
      // result side first: a result at this edge can only belong to an older beat
      if (res_valid && !res_stall) begin
        n_seen++;
        if (cleaned_q.size() == 0) begin
          log_mismatch($sformatf("unexpected result %0d/%0b", res_beat.pixel_out,
                                 res_beat.frame_end));
        end else begin
          want = cleaned_q.pop_front();
          if (res_beat.pixel_out !== want.pixel_out)
            log_mismatch($sformatf("result %0d pixel_out %0d, want %0d", n_seen,
                                   res_beat.pixel_out, want.pixel_out));
          if (res_beat.frame_end !== want.frame_end)
            log_mismatch($sformatf("result %0d frame_end %0b, want %0b", n_seen,
                                   res_beat.frame_end, want.frame_end));
        end
      end
      if (px_valid && !px_stall) begin
        w = clamp_dim(width_reg, DEF_MAX_WIDTH);
        h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
        if (px_beat.kind == KIND_FLUSH) begin
          if (held != 0) cleaned_q.push_back(clean_oldest(w, h));
        end else begin
          ring_px[wr_pos] = px_beat.pixel_in;
          wr_pos = (wr_pos + 1) % RING;
          held++;
          next_pos(in_row, in_col, w, h);
          if (held > w + 1) cleaned_q.push_back(clean_oldest(w, h));
        end
      end
    end
    due_count <= cleaned_q.size();
    fail_count <= n_fail;
    result_count <= n_seen;
  end

endmodule

/* verif/tb.sv */
// Testbench top for the isolated pixel remover: stimulus, flow control, watchdog and verdict.
module tb;
  import ipr_pkg::*;

  localparam int HOLD_CYCLES = 300;   // long receiver hold-off, fills the result queue
  localparam int QUIET_LIMIT = 4000;  // cycles with no beat, config write or reset
  localparam int TAIL        = 10;    // settle time after the last expected result
  localparam int ITEM_GOAL   = 700;   // input beats wanted over the whole run

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  cfg_reg_t         cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             px_valid = 1'b0;
  in_beat_t         px_beat = '0;
  logic             px_stall;
  logic             res_valid;
  logic             res_stall = 1'b0;
  out_beat_t        res_beat;

  int n_due, n_fail, n_checked;

  // stimulus knobs and counters; the flags and the hold count are written with NBAs at the clock edge
  logic no_idle = 1'b0;
  logic hold_start = 1'b0;
  logic hold_used = 1'b0;
  int   hold_left = 0;
  int   zero_pct = 50;
  int   pix_sent = 0, flush_sent = 0, settings = 0;

  always #1 clk = ~clk;

  isolated_pixel_removal u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .px_valid (px_valid),
    .px_stall (px_stall),
    .px_beat  (px_beat),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_beat (res_beat)
  );

  ipr_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .px_valid    (px_valid),
    .px_stall    (px_stall),
    .px_beat     (px_beat),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res_beat    (res_beat),
    .due_count   (n_due),
    .fail_count  (n_fail),
    .result_count(n_checked)
  );

  // Result side: random stalls, one long hold-off on request, none during the quiet phase.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_start && !hold_used) begin
      res_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      hold_used <= 1'b1;
    end else begin
      res_stall <= !no_idle && ($urandom_range(99) < 19);
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (px_valid && !px_stall) || (res_valid && !res_stall)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no beat accepted for %0d cycles", QUIET_LIMIT);
    $display("status: fail");
    $finish;
  end

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned lim);
    int unsigned d;
    d = v;
    if (d < 1) d = 1;
    if (d > lim) d = lim;
    return d;
  endfunction

  // Mostly black and white with some gray, so that lone whites turn up often.
  function automatic pixel_t pick_pixel();
    int r;
    r = $urandom_range(99);
    if (r < zero_pct) return '0;
    if (r < zero_pct + (100 - zero_pct) * 3 / 4) return PIX_WHITE;
    return pixel_t'($urandom_range(255));
  endfunction

  // Offers one beat, with random idle cycles first, and returns at the edge that takes it.
  // Valid stays high afterwards so that back-to-back beats need no second assignment.
  task automatic send_beat(input kind_t k, input pixel_t p);
    while (!no_idle && $urandom_range(99) < 19) begin
      px_valid <= 1'b0;
      @(posedge clk);
    end
    px_valid <= 1'b1;
    px_beat <= in_beat_t'{kind: k, pixel_in: p};
    @(posedge clk);
    while (px_stall) @(posedge clk);
    if (k == KIND_FLUSH) flush_sent++;
    else pix_sent++;
  endtask

  task automatic send_flush();
    send_beat(KIND_FLUSH, pixel_t'($urandom_range(255)));
  endtask

  // Lowers valid and waits until every predicted result has come out.
  task automatic wait_drained();
    px_valid <= 1'b0;
    @(posedge clk);
    while (n_due != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
  endtask

  // Both registers, back to back; only called while the block is idle.
  task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    cfg_we <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // One size setting: n pixel beats with scattered flush bursts, then a full drain.
  task automatic run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                           input int n, input bit pause_mid);
    int unsigned ew, burst, drain;
    set_size(w, h);
    ew = clamp_dim(w, DEF_MAX_WIDTH);
    zero_pct = $urandom_range(35, 85);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 4) begin
        // flush burst inside the frame; long ones also hit the empty case
        burst = $urandom_range(1, (ew + 3 < 12) ? ew + 3 : 12);
        repeat (burst) send_flush();
      end
      send_beat(KIND_PIXEL, pick_pixel());
      if (pause_mid && i == n / 2) wait_drained();
    end
    // pending never exceeds width+1 nor this phase's pixel beats; one spare flush
    drain = (n + 1 < ew + 2) ? n + 1 : ew + 2;
    repeat (drain) send_flush();
    wait_drained();
  endtask

  initial begin : stimulus
    int unsigned w, h, n;
    int          phase;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset sizes (640x480): row-0 beats pass through, the last flush finds nothing.
    send_beat(KIND_PIXEL, PIX_WHITE);
    send_beat(KIND_PIXEL, 8'd7);
    repeat (3) send_flush();
    wait_drained();

    // 3x3 frames. First one: lone white center gets cleared.
    set_size(11'd3, 11'd3);
    for (int i = 0; i < 9; i++) send_beat(KIND_PIXEL, (i == 4) ? PIX_WHITE : 8'd0);
    // Second one back to back: flushes judge the center before its right and lower
    // neighbors arrive; one lit neighbor is still few enough to clear it.
    for (int i = 0; i < 9; i++) begin
      if (i == 5) repeat (4) send_flush();
      send_beat(KIND_PIXEL, (i == 0 || i == 4 || i == 5) ? PIX_WHITE : 8'd0);
    end
    repeat (5) send_flush();
    wait_drained();

    phase = 0;
    while (phase < 9 || pix_sent + flush_sent < ITEM_GOAL) begin
      no_idle <= (phase == 0);
      case (phase)
        0: run_phase(11'd8, 11'd5, 80, 1'b0);       // no idling on either side
        1: begin                                    // receiver hold-off fills the block
          hold_start <= 1'b1;
          run_phase(11'd4, 11'd6, 72, 1'b0);
        end
        2: run_phase(11'd6, 11'd4, 48, 1'b1);       // sender pauses mid-frame
        3: run_phase(11'd2047, 11'd2047, 40, 1'b0); // both saturate
        4: run_phase(11'd1024, 11'd1, 40, 1'b0);    // widest row, flushes release part of it
        5: run_phase(11'd0, 11'd0, 6, 1'b0);        // zero counts as one
        6: run_phase(11'd1, 11'd1, 5, 1'b0);
        7: run_phase(11'd2, 11'd2, 12, 1'b0);
        8: run_phase(11'd3, 11'd1024, 60, 1'b0);
        default: begin
          w = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
          h = $urandom_range(1, 8);
          n = $urandom_range(1, 3) * w * h;
          if (n > 40) n = 40;
          if ($urandom_range(3) == 0) n = $urandom_range(1, n); // stop mid-frame
          // now and then write zero as the width, which counts as one
          if ($urandom_range(15) == 0) run_phase(11'd0, 11'(h), n, 1'b0);
          else run_phase(11'(w), 11'(h), n, 1'b0);
        end
      endcase
      phase++;
    end

    wait_drained();
    $display("covered %0d pixel beats and %0d flush beats over %0d size settings",
             pix_sent, flush_sent, settings);
    $display("%0d results compared, %0d mismatches", n_checked, n_fail);
    if (n_fail == 0 && n_due == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

/* filelist.f */
sv/ipr_pkg.sv
sv/ipr_ring.sv
sv/ipr_line.sv
sv/ipr_judge.sv
sv/ipr_oq.sv
sv/isolated_pixel_removal.sv
sv/ipr_checker.sv
verif/ipr_checker.sv
verif/tb.sv
